### hw/rtl/kmeans_clustering_assert.svh
// Assertion macros shared by the k-means clustering RTL.
// Used at the end of the top level; needs no other file.
`ifndef KMEANS_CLUSTERING_ASSERT_SVH
`define KMEANS_CLUSTERING_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define KM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked on every rising clock edge outside reset.
`define KM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

### hw/rtl/km_pkg.sv
// Types and constants shared by the k-means clustering block.
// Depends on nothing.
package km_pkg;
    localparam int unsigned CoordW = 16;
    localparam int unsigned NumCoord = 4;
    localparam int unsigned DistW = 37;
    localparam int unsigned SumW = 23;
    localparam int unsigned KW = 4;
    localparam int unsigned CidW = 3;
    localparam int unsigned PidxW = 6;

    typedef logic signed [CoordW-1:0] t_coord;
    typedef t_coord [NumCoord-1:0] t_vec;

    typedef struct packed {
        logic signed [CoordW-1:0] coord_0;
        logic signed [CoordW-1:0] coord_1;
        logic signed [CoordW-1:0] coord_2;
        logic signed [CoordW-1:0] coord_3;
        logic                     last_point;
    } t_in_item;

    typedef struct packed {
        logic [PidxW-1:0] point_index;
        logic [CidW-1:0]  cluster_id;
        logic             converged;
        logic             too_few_points;
        logic             last_result;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_INIT,
        ST_RD,
        ST_ASSIGN,
        ST_ACC,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_PASS_END,
        ST_EMIT
    } t_state;
endpackage

### hw/rtl/km_lane.sv
// One distance lane: squared distance from a point to one centroid.
// Uses km_pkg; one registered square per coordinate, then a registered sum.
module km_lane #(
    parameter int unsigned DIMS = 4
) (
    input  logic          i_clk,
    input  km_pkg::t_vec  i_point,
    input  km_pkg::t_vec  i_centroid,
    output logic [km_pkg::DistW-1:0] o_dist
);
    import km_pkg::*;

    logic [2*CoordW+1:0] r_sq [NumCoord];
    logic [DistW-1:0] n_sum;
    logic [DistW-1:0] r_dist;
    logic signed [CoordW:0] diff [NumCoord];
    logic signed [2*CoordW+1:0] sq [NumCoord];

    always_comb begin
        for (int d = 0; d < NumCoord; d++) begin
            diff[d] = {i_point[d][CoordW-1], i_point[d]} -
                {i_centroid[d][CoordW-1], i_centroid[d]};
            sq[d] = diff[d] * diff[d];
        end
        n_sum = '0;
        for (int d = 0; d < NumCoord; d++) begin
            if (d < DIMS) begin
                n_sum = n_sum + DistW'(r_sq[d]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int d = 0; d < NumCoord; d++) begin
            r_sq[d] <= sq[d];
        end
        r_dist <= n_sum;
    end

    assign o_dist = r_dist;
endmodule

### hw/rtl/km_merge.sv
// Merging stage: picks the lowest-index lane at the least distance.
// Uses km_pkg; a registered compare chain over the lane distances.
module km_merge #(
    parameter int unsigned LANES = 8
) (
    input  logic                     i_clk,
    input  logic [km_pkg::DistW-1:0] i_dist [LANES],
    input  logic [km_pkg::KW-1:0]    i_k,
    output logic [km_pkg::CidW-1:0]  o_best
);
    import km_pkg::*;

    logic [DistW-1:0] bd;
    logic [CidW-1:0]  bi;
    logic [CidW-1:0]  r_best;

    always_comb begin
        bd = i_dist[0];
        bi = '0;
        for (int c = 1; c < LANES; c++) begin
            if (KW'(c) < i_k && i_dist[c] < bd) begin
                bd = i_dist[c];
                bi = CidW'(c);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_best <= bi;
    end

    assign o_best = r_best;
endmodule

### hw/rtl/km_div.sv
// Restoring divider for centroid means, truncating toward zero.
// Uses km_pkg; one quotient bit per cycle.
module km_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic signed [km_pkg::SumW-1:0] i_num,
    input  logic [6:0]                i_den,
    output logic                      o_done,
    output logic signed [km_pkg::CoordW-1:0] o_quot
);
    import km_pkg::*;

    localparam int unsigned CntW = $clog2(SumW + 1);

    logic [SumW-1:0] r_q;
    logic [7:0]      r_rem;
    logic [6:0]      r_den;
    logic            r_neg;
    logic [CntW-1:0] r_cnt;
    logic            r_busy;
    logic            r_done;
    logic [7:0]      n_rem;
    logic [SumW-1:0] mag;
    logic [SumW-1:0] qs;

    always_comb begin
        n_rem = {r_rem[6:0], r_q[SumW-1]};
        mag = i_num[SumW-1] ? SumW'(-i_num) : SumW'(i_num);
        qs = r_neg ? SumW'(-r_q) : r_q;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CntW'(SumW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CntW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
        if (i_start) begin
            r_q   <= mag;
            r_rem <= '0;
            r_den <= i_den;
            r_neg <= i_num[SumW-1];
        end else if (r_busy) begin
            if (n_rem >= {1'b0, r_den}) begin
                r_rem <= n_rem - {1'b0, r_den};
                r_q   <= {r_q[SumW-2:0], 1'b1};
            end else begin
                r_rem <= n_rem;
                r_q   <= {r_q[SumW-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = qs[CoordW-1:0];
endmodule

### hw/rtl/kmeans_clustering.sv
// Lloyd k-means over up to MAX_POINTS points: one point accepted per cycle while loading.
// After the last point: a setup state, then per pass every point is read, assigned by the
// lanes and merge and accumulated; each used coordinate of non-empty clusters is divided.
// Up to MAX_ITER passes. Results follow one per cycle, one per point, with no stalls.
// Synchronous active-low reset returns to loading with no points and num_clusters 2.
// Depends on km_pkg, km_lane, km_merge, km_div and kmeans_clustering_assert.svh.
`include "kmeans_clustering_assert.svh"
module kmeans_clustering #(
    parameter int unsigned MAX_POINTS   = 64,
    parameter int unsigned MAX_CLUSTERS = 8,
    parameter int unsigned DIMS         = 4,
    parameter int unsigned MAX_ITER     = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  km_pkg::t_in_item   i_item,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [km_pkg::KW-1:0] i_cfg_data,
    output logic               o_valid,
    output km_pkg::t_out_item  o_item
);
    import km_pkg::*;

    localparam int unsigned PW  = $clog2(MAX_POINTS);
    localparam int unsigned PCW = $clog2(MAX_POINTS + 1);
    localparam int unsigned KIW = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
    localparam int unsigned IW  = $clog2(MAX_ITER + 1);
    localparam int unsigned DW  = 2;
    localparam int unsigned CW  = 7;

    t_state r_state, n_state;
    logic [KW-1:0]  r_k_cfg;
    logic [KW-1:0]  r_k;
    logic [PCW-1:0] r_count;
    logic [PCW-1:0] r_p;
    logic [PW-1:0]  r_rd_addr;
    logic [IW-1:0]  r_iter;
    logic           r_changed;
    logic           r_conv;
    logic           r_few;
    logic [2:0]     r_wait;
    logic [KIW-1:0] r_c;
    logic [DW-1:0]  r_d;
    logic           r_out_valid;
    t_out_item      r_out;

    t_vec           r_pmem [MAX_POINTS];
    logic [CidW-1:0] r_amem [MAX_POINTS];
    t_vec           r_pt;
    logic [CidW-1:0] r_as;
    t_vec           r_cent [MAX_CLUSTERS];
    logic signed [SumW-1:0] r_sum [MAX_CLUSTERS][NumCoord];
    logic [CW-1:0]  r_cnt [MAX_CLUSTERS];

    logic [DistW-1:0] lane_dist [MAX_CLUSTERS];
    logic [CidW-1:0]  best;
    logic             div_start;
    logic             div_done;
    logic signed [CoordW-1:0] quot;
    logic [KW-1:0]    k_eff;
    logic             accept;
    t_vec             in_vec;
    logic             pass_last;

    always_comb begin
        k_eff = (r_k_cfg == '0) ? KW'(1) : r_k_cfg;
        if (k_eff > KW'(MAX_CLUSTERS)) begin
            k_eff = KW'(MAX_CLUSTERS);
        end
        in_vec[0] = i_item.coord_0;
        in_vec[1] = i_item.coord_1;
        in_vec[2] = i_item.coord_2;
        in_vec[3] = i_item.coord_3;
    end

    assign busy = (r_state != ST_LOAD);
    assign accept = start && !busy;
    assign o_cfg_ready = (r_state == ST_LOAD);

    for (genvar g = 0; g < MAX_CLUSTERS; g++) begin : g_lane
        km_lane #(.DIMS(DIMS)) u_lane (
            .i_clk(i_clk), .i_point(r_pt), .i_centroid(r_cent[g]), .o_dist(lane_dist[g])
        );
    end

    km_merge #(.LANES(MAX_CLUSTERS)) u_merge (
        .i_clk(i_clk), .i_dist(lane_dist), .i_k(r_k), .o_best(best)
    );

    km_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_num(r_sum[r_c][r_d]), .i_den(r_cnt[r_c]), .o_done(div_done), .o_quot(quot)
    );

    assign pass_last = (r_p == r_count - 1'b1);

    always_comb begin
        n_state = r_state;
        div_start = 1'b0;
        unique case (r_state)
            ST_LOAD: begin
                if (accept && i_item.last_point) begin
                    n_state = ST_INIT;
                end
            end
            ST_INIT: begin
                n_state = (r_count < PCW'(r_k)) ? ST_EMIT : ST_RD;
            end
            ST_RD: n_state = ST_ASSIGN;
            ST_ASSIGN: begin
                if (r_wait == 3'd4) begin
                    n_state = ST_ACC;
                end
            end
            ST_ACC: n_state = pass_last ? ST_DIV_START : ST_RD;
            ST_DIV_START: begin
                if (r_cnt[r_c] == '0 || 32'(r_d) >= DIMS) begin
                    n_state = ST_PASS_END;
                end else begin
                    div_start = 1'b1;
                    n_state = ST_DIV_WAIT;
                end
            end
            ST_DIV_WAIT: begin
                if (div_done) begin
                    n_state = ST_DIV_START;
                end
            end
            ST_PASS_END: begin
                if (KW'(r_c) == r_k - 1'b1) begin
                    if (!r_changed || r_iter == IW'(MAX_ITER - 1)) begin
                        n_state = ST_EMIT;
                    end else begin
                        n_state = ST_RD;
                    end
                end else begin
                    n_state = ST_DIV_START;
                end
            end
            ST_EMIT: begin
                if (pass_last) begin
                    n_state = ST_LOAD;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k_cfg     <= KW'(2);
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= (r_state == ST_EMIT);
            if (i_cfg_valid && o_cfg_ready) begin
                r_k_cfg <= i_cfg_data;
            end
            if (accept && r_count < PCW'(MAX_POINTS)) begin
                r_count <= r_count + 1'b1;
            end
            if (r_state == ST_EMIT && pass_last) begin
                r_count <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && r_count < PCW'(MAX_POINTS)) begin
            r_pmem[r_count[PW-1:0]] <= in_vec;
        end
        r_pt <= r_pmem[r_rd_addr];
        r_as <= r_amem[r_rd_addr];
        if (r_state == ST_ACC) begin
            r_amem[r_p[PW-1:0]] <= best;
        end
    end

    always_comb begin
        r_rd_addr = r_p[PW-1:0];
        if (r_state == ST_INIT || r_state == ST_PASS_END) begin
            r_rd_addr = '0;
        end else if (r_state == ST_ACC || r_state == ST_EMIT) begin
            r_rd_addr = pass_last ? '0 : PW'(r_p + 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_LOAD: begin
                r_k     <= k_eff;
                r_iter  <= '0;
                r_conv  <= 1'b0;
                r_few   <= 1'b0;
                r_p     <= '0;
                r_c     <= '0;
                r_d     <= '0;
                r_wait  <= '0;
                r_changed <= 1'b0;
                if (accept && 32'(r_count) < 32'(MAX_CLUSTERS)) begin
                    r_cent[KIW'(r_count)] <= in_vec;
                end
                for (int c = 0; c < MAX_CLUSTERS; c++) begin
                    r_cnt[c] <= '0;
                    for (int d = 0; d < NumCoord; d++) begin
                        r_sum[c][d] <= '0;
                    end
                end
            end
            ST_INIT: begin
                r_few <= (r_count < PCW'(r_k));
                r_p   <= '0;
            end
            ST_RD: r_wait <= '0;
            ST_ASSIGN: r_wait <= r_wait + 1'b1;
            ST_ACC: begin
                r_cnt[best] <= r_cnt[best] + 1'b1;
                for (int d = 0; d < NumCoord; d++) begin
                    r_sum[best][d] <= r_sum[best][d] + SumW'(r_pt[d]);
                end
                if (pass_last) begin
                    r_p <= '0;
                    r_c <= '0;
                    r_d <= '0;
                end else begin
                    r_p <= r_p + 1'b1;
                end
            end
            ST_DIV_START: ;
            ST_DIV_WAIT: begin
                if (div_done) begin
                    if (quot != r_cent[r_c][r_d]) begin
                        r_changed <= 1'b1;
                    end
                    r_cent[r_c][r_d] <= quot;
                    if (r_d == DW'(NumCoord - 1)) begin
                        r_cnt[r_c] <= '0;
                    end else begin
                        r_d <= r_d + 1'b1;
                    end
                end
            end
            ST_PASS_END: begin
                r_d <= '0;
                if (KW'(r_c) == r_k - 1'b1) begin
                    r_c <= '0;
                    r_iter <= r_iter + 1'b1;
                    r_changed <= 1'b0;
                    r_conv <= !r_changed;
                    for (int c = 0; c < MAX_CLUSTERS; c++) begin
                        r_cnt[c] <= '0;
                        for (int d = 0; d < NumCoord; d++) begin
                            r_sum[c][d] <= '0;
                        end
                    end
                end else begin
                    r_c <= r_c + 1'b1;
                end
            end
            ST_EMIT: begin
                r_out.point_index    <= PidxW'(r_p);
                r_out.cluster_id     <= r_few ? '0 : r_as;
                r_out.converged      <= r_conv;
                r_out.too_few_points <= r_few;
                r_out.last_result    <= pass_last;
                r_p <= r_p + 1'b1;
            end
            default: ;
        endcase
        if (r_state == ST_DIV_START && r_cnt[r_c] == '0) begin
            r_d <= '0;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

    `KM_ASSERT_IMP(a_no_accept_busy, i_clk, i_rst_n, busy, !accept, "item taken while busy")
    `KM_ASSERT_IMP(a_cfg_idle, i_clk, i_rst_n, i_cfg_valid && o_cfg_ready, !busy,
        "configuration taken during a run")
    `KM_ASSERT_NEXT(a_emit_strobe, i_clk, i_rst_n, r_state == ST_EMIT, o_valid,
        "result strobe missing")
    `KM_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= PCW'(MAX_POINTS),
        "point count beyond capacity")
endmodule

### tb/tb_kmeans_clustering.sv
// Self-checking testbench for the kmeans_clustering block: streams point sets, predicts
// the cluster of every point with its own Lloyd k-means model and checks each result item.
// Depends on km_pkg and the kmeans_clustering RTL.
module tb_kmeans_clustering;
    timeunit 1ns;
    timeprecision 1ps;
    import km_pkg::*;

    localparam int unsigned NPTS = 64;
    localparam int unsigned NCL = 8;
    localparam int unsigned NITER = 64;
    localparam longint unsigned CYCLE_LIMIT = 64'd20_000_000;

    class cluster_board;
        t_out_item pending[$];
        int unsigned errors;
        int unsigned checked;
        int signed pts[NPTS][4];
        int unsigned npts;
        logic [KW-1:0] k_reg;

        function new();
            errors = 0;
            checked = 0;
            npts = 0;
            k_reg = 4'd2;
        endfunction

        function longint unsigned sq_distance(int signed a[4], int signed b[4]);
            longint unsigned s;
            longint signed df;
            s = 0;
            for (int d = 0; d < 4; d++) begin
                df = longint'(a[d]) - longint'(b[d]);
                s += longint'(df * df);
            end
            return s;
        endfunction

        function void note_point(t_in_item it);
            int unsigned k;
            bit few;
            bit conv;
            bit moved;
            int unsigned best;
            longint unsigned bd;
            longint unsigned dd;
            int signed cen[NCL][4];
            int unsigned asg[NPTS];
            longint signed sums[NCL][4];
            int unsigned cnt[NCL];
            int signed m;
            t_out_item r;
            if (npts < NPTS) begin
                pts[npts][0] = it.coord_0;
                pts[npts][1] = it.coord_1;
                pts[npts][2] = it.coord_2;
                pts[npts][3] = it.coord_3;
                npts++;
            end
            if (!it.last_point) return;
            k = k_reg;
            if (k == 0) k = 1;
            if (k > NCL) k = NCL;
            few = npts < k;
            conv = 0;
            if (!few) begin
                for (int c = 0; c < k; c++) cen[c] = pts[c];
                for (int it_n = 0; it_n < NITER; it_n++) begin
                    moved = 0;
                    for (int c = 0; c < NCL; c++) begin
                        cnt[c] = 0;
                        for (int d = 0; d < 4; d++) sums[c][d] = 0;
                    end
                    for (int p = 0; p < npts; p++) begin
                        best = 0;
                        bd = sq_distance(pts[p], cen[0]);
                        for (int c = 1; c < k; c++) begin
                            dd = sq_distance(pts[p], cen[c]);
                            if (dd < bd) begin
                                bd = dd;
                                best = c;
                            end
                        end
                        asg[p] = best;
                        cnt[best]++;
                        for (int d = 0; d < 4; d++) sums[best][d] += pts[p][d];
                    end
                    for (int c = 0; c < k; c++) begin
                        if (cnt[c] != 0) begin
                            for (int d = 0; d < 4; d++) begin
                                m = int'(sums[c][d] / longint'(cnt[c]));
                                if (m != cen[c][d]) moved = 1;
                                cen[c][d] = m;
                            end
                        end
                    end
                    if (!moved) begin
                        conv = 1;
                        break;
                    end
                end
            end
            for (int p = 0; p < npts; p++) begin
                r.point_index = p[PidxW-1:0];
                r.cluster_id = few ? '0 : asg[p][CidW-1:0];
                r.converged = conv;
                r.too_few_points = few;
                r.last_result = (p + 1 == npts);
                pending.insert(pending.size(), r);
            end
            npts = 0;
        endfunction

        function void check_result(t_out_item got);
            t_out_item exp;
            checked++;
            if (pending.size() == 0) begin
                $error("unexpected result item %p", got);
                errors++;
                return;
            end
            exp = pending[0];
            pending.delete(0);
            if (got.point_index !== exp.point_index) begin
                $error("point_index exp %0d got %0d", exp.point_index, got.point_index);
                errors++;
            end
            if (got.cluster_id !== exp.cluster_id) begin
                $error("cluster_id exp %0d got %0d", exp.cluster_id, got.cluster_id);
                errors++;
            end
            if (got.converged !== exp.converged) begin
                $error("converged exp %0d got %0d", exp.converged, got.converged);
                errors++;
            end
            if (got.too_few_points !== exp.too_few_points) begin
                $error("too_few_points exp %0d got %0d", exp.too_few_points,
                       got.too_few_points);
                errors++;
            end
            if (got.last_result !== exp.last_result) begin
                $error("last_result exp %0d got %0d", exp.last_result, got.last_result);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    t_in_item i_item;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic [KW-1:0] i_cfg_data;
    logic o_valid;
    t_out_item o_item;

    cluster_board board;
    longint unsigned cycles = 0;
    int unsigned points_sent;
    int unsigned runs;
    int unsigned burst_left;

    kmeans_clustering i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_item(i_item),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data(i_cfg_data),
        .o_valid(o_valid),
        .o_item(o_item)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && o_valid) board.check_result(o_item);
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic send_point(input logic signed [15:0] c0, input logic signed [15:0] c1,
                              input logic signed [15:0] c2, input logic signed [15:0] c3,
                              input logic lastp);
        t_in_item it;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6)) @(negedge i_clk);
        end
        burst_left--;
        it.coord_0 = c0;
        it.coord_1 = c1;
        it.coord_2 = c2;
        it.coord_3 = c3;
        it.last_point = lastp;
        i_item = it;
        start = 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        board.note_point(it);
        points_sent++;
        if (lastp) runs++;
        @(negedge i_clk);
        start = 1'b0;
    endtask

    task automatic wait_drained();
        while (board.pending.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic write_k(input logic [KW-1:0] k);
        wait_drained();
        i_cfg_data <= k;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        board.k_reg = k;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_random_set(input int unsigned n, input int unsigned spread);
        logic signed [15:0] v[4];
        for (int p = 0; p < n; p++) begin
            for (int d = 0; d < 4; d++) begin
                if (spread == 0) v[d] = 16'($urandom);
                else v[d] = 16'($urandom_range(0, spread) - spread / 2 + (p % 3) * spread * 2);
            end
            send_point(v[0], v[1], v[2], v[3], p == n - 1);
        end
    endtask

    initial begin
        board = new();
        points_sent = 0;
        runs = 0;
        burst_left = 0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_item = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        send_point(16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF, 1'b0);
        send_point(16'sh8000, 16'sh7FFF, 16'shFFFF, 16'sh0000, 1'b0);
        send_point(16'sh0001, 16'sh0000, 16'sh7FFF, 16'sh8000, 1'b1);
        send_point(16'sh0100, 16'sh0100, 16'sh0100, 16'sh0100, 1'b1);
        write_k(4'd0);
        send_point(16'sh0005, 16'sh0006, 16'sh0007, 16'sh0008, 1'b1);
        write_k(4'd15);
        send_random_set(3, 0);
        write_k(4'd8);
        send_point(16'sh0010, 16'sh0010, 16'sh0010, 16'sh0010, 1'b0);
        send_point(16'sh0010, 16'sh0010, 16'sh0010, 16'sh0010, 1'b0);
        send_random_set(8, 400);
        write_k(4'd1);
        send_random_set(66, 0);
        write_k(4'd3);

        while (points_sent < 120) begin
            if ($urandom_range(0, 4) == 0) write_k(KW'($urandom_range(0, 15)));
            if ($urandom_range(0, 3) == 0) wait_drained();
            send_random_set($urandom_range(1, 14), $urandom_range(0, 1) ? 0 : 3000);
        end

        wait_drained();
        repeat (200) @(negedge i_clk);
        $display("Covered %0d points in %0d clustering runs, %0d result items checked.",
                 points_sent, runs, board.checked);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
